[rtl/uuidv_pkg.sv]
// ----------------------------------------------------------------------------
// uuidv_pkg
// Shared types and constants for the UUID text validator.
// ----------------------------------------------------------------------------
package uuidv_pkg;

   localparam int POS_WIDTH = 6;

   localparam logic [POS_WIDTH-1:0] POS_LIMIT   = 6'd37;
   localparam logic [POS_WIDTH-1:0] COMPACT_LEN = 6'd32;
   localparam logic [POS_WIDTH-1:0] DASHED_LEN  = 6'd36;

   localparam logic [POS_WIDTH-1:0] DASH_POS_0 = 6'd8;
   localparam logic [POS_WIDTH-1:0] DASH_POS_1 = 6'd13;
   localparam logic [POS_WIDTH-1:0] DASH_POS_2 = 6'd18;
   localparam logic [POS_WIDTH-1:0] DASH_POS_3 = 6'd23;

   localparam logic [7:0] DASH_CHAR = 8'h2D;

   // Classification of one byte.
   typedef struct packed {
      logic is_ws;
      logic is_hex;
      logic is_dash;
   } char_class_type;

endpackage

[rtl/uuidv_char_class.sv]
// ----------------------------------------------------------------------------
// uuidv_char_class
// Classify one byte as whitespace, hex digit or dash.
// ----------------------------------------------------------------------------
module uuidv_char_class (
   input  logic [7:0]                char_code,
   output uuidv_pkg::char_class_type char_class
);
   import uuidv_pkg::*;

   always_comb begin
      char_class.is_ws   = (char_code == 8'h20) ||
                           ((char_code >= 8'h09) && (char_code <= 8'h0D));
      char_class.is_hex  = ((char_code >= 8'h30) && (char_code <= 8'h39)) ||
                           ((char_code >= 8'h61) && (char_code <= 8'h66)) ||
                           ((char_code >= 8'h41) && (char_code <= 8'h46));
      char_class.is_dash = (char_code == DASH_CHAR);
   end

endmodule

[rtl/uuidv_scan.sv]
// ----------------------------------------------------------------------------
// uuidv_scan
// Per-string scan state: position counters and form flags, plus the verdict.
// ----------------------------------------------------------------------------
module uuidv_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      end_of_string,
   input  uuidv_pkg::char_class_type char_class,
   output logic                      verdict
);
   import uuidv_pkg::*;

   logic                 seen_nonspace_ff, seen_nonspace_in;
   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic [POS_WIDTH-1:0] trimmed_length_ff, trimmed_length_in;
   logic                 compact_ok_ff, compact_ok_in;
   logic                 dashed_ok_ff, dashed_ok_in;

   logic                 dash_pos;
   logic [POS_WIDTH-1:0] pos_inc;

   assign dash_pos = (position_ff == DASH_POS_0) || (position_ff == DASH_POS_1) ||
                     (position_ff == DASH_POS_2) || (position_ff == DASH_POS_3);
   assign pos_inc  = (position_ff < POS_LIMIT) ? position_ff + 6'd1 : position_ff;

   assign verdict = ((trimmed_length_ff == COMPACT_LEN) && compact_ok_ff) ||
                    ((trimmed_length_ff == DASHED_LEN) && dashed_ok_ff);

   always_comb begin
      seen_nonspace_in  = seen_nonspace_ff;
      position_in       = position_ff;
      trimmed_length_in = trimmed_length_ff;
      compact_ok_in     = compact_ok_ff;
      dashed_ok_in      = dashed_ok_ff;
      priority if (end_of_string) begin
         seen_nonspace_in  = 1'b0;
         position_in       = '0;
         trimmed_length_in = '0;
         compact_ok_in     = 1'b1;
         dashed_ok_in      = 1'b1;
      end else if (char_class.is_ws) begin
         if (seen_nonspace_ff) begin
            position_in = pos_inc;
         end
      end else begin
         seen_nonspace_in = 1'b1;
         // whitespace between this byte and the previous one
         if (position_ff != trimmed_length_ff) begin
            compact_ok_in = 1'b0;
            dashed_ok_in  = 1'b0;
         end
         if ((position_ff < COMPACT_LEN) && !char_class.is_hex) begin
            compact_ok_in = 1'b0;
         end
         if (position_ff < DASHED_LEN) begin
            if (dash_pos) begin
               if (!char_class.is_dash) begin
                  dashed_ok_in = 1'b0;
               end
            end else if (!char_class.is_hex) begin
               dashed_ok_in = 1'b0;
            end
         end
         position_in       = pos_inc;
         trimmed_length_in = pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_nonspace_ff  <= 1'b0;
         position_ff       <= '0;
         trimmed_length_ff <= '0;
         compact_ok_ff     <= 1'b1;
         dashed_ok_ff      <= 1'b1;
      end else if (step) begin
         seen_nonspace_ff  <= seen_nonspace_in;
         position_ff       <= position_in;
         trimmed_length_ff <= trimmed_length_in;
         compact_ok_ff     <= compact_ok_in;
         dashed_ok_ff      <= dashed_ok_in;
      end
   end

endmodule

[rtl/uuid_text_validator.sv]
// ----------------------------------------------------------------------------
// uuid_text_validator
// Stream checker that tells whether a text string is a UUID.
// ----------------------------------------------------------------------------
// Send the string one byte per transaction on req_, and close it with a
// transaction that has req_tlast set (its data byte is ignored). For each
// closing transaction the block returns one rsp_ transaction whose bit 0 is
// 1 when the string, with leading and trailing whitespace removed, is either
// 32 hex digits or the dashed 8-4-4-4-12 form of 36 characters. Whitespace
// is space, tab, newline, vertical tab, form feed and carriage return; hex
// digits may be either case. Bytes are accepted at one per cycle unless
// the input register holds. A byte sits in the input register and updates
// the scan state as it leaves; a closing transaction loads the verdict
// into the result register as it leaves. The input register
// holds only while a closing transaction waits for a stalled result slot.
// ----------------------------------------------------------------------------
module uuid_text_validator (
   input  logic       clock,
   input  logic       reset,
   // request stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_string
   // response stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_valid, [7:1] zero
);
   import uuidv_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_is_valid_ff;

   logic           s1_advance;
   logic           rsp_free;
   logic           verdict;
   char_class_type char_class;

   // A result slot is free when empty or being drained this cycle.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // Plain bytes always leave; a closing transaction needs the result slot.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_tready = !s1_valid_ff || s1_advance;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = (s1_advance && s1_last_ff) ? 1'b1
                       : (rsp_tready ? 1'b0 : rsp_valid_ff);

   uuidv_char_class u_char_class (
      .char_code  (s1_char_ff),
      .char_class (char_class)
   );

   uuidv_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_advance),
      .end_of_string (s1_last_ff),
      .char_class    (char_class),
      .verdict       (verdict)
   );

   // Control: valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load input on accept, latch verdict when a string closes
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_is_valid_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_is_valid_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A new result only ever follows a closing transaction leaving stage one.
   a_rsp_from_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) ##1 rsp_valid_ff |->
         $past(s1_advance && s1_last_ff))
      else $error("result appeared without a closing transaction");

   // Plain bytes never stall in the input register.
   a_byte_no_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_last_ff) |-> (s1_advance && req_tready))
      else $error("plain byte stalled in input register");

   // A closing transaction held back only when the result slot is busy.
   a_last_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && !s1_advance) |-> (rsp_valid_ff && !rsp_tready))
      else $error("closing transaction held without a stalled result");

endmodule
